FILE: rtl/olms_pkg.sv
// Shared types, constants and helper functions for the outpoint min-hash lane select.
`default_nettype none
package olms_pkg;

  // One queued outpoint beat.
  typedef struct packed {
    logic [3:0][63:0] id;      // id[0] holds id_word0
    logic [31:0]      idx;
    logic             last;
    logic             noin;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HASH,
    BK_MOD,
    BK_OUT
  } bk_state_t;

  localparam logic [7:0][31:0] SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] SHA_PAD_ONE   = 32'h80000000;
  localparam logic [31:0] SHA_LEN_BLK1  = 32'd288;
  localparam logic [31:0] SHA_LEN_BLK2  = 32'd256;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] x);
    return {swap32(x[31:0]), swap32(x[63:32])};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/outpoint_min_hash_lane_select_core.sv
// Top level of the outpoint min-hash lane select: queue front end and hashing back end.
// Flow: an outpoint is popped from the queue and hashed by the double SHA-256 engine
//   (two 64-round compressions on one round unit, each followed by a finalize step).
// The back end takes the next outpoint only after it is done with the last; a last
//   outpoint adds lane reduction and an output step; a no-inputs beat skips the hash.
// Reset: synchronous active-low rst_n empties the queue, drops the held digest and
//   the pending result.
`default_nettype none
module outpoint_min_hash_lane_select_core #(
  parameter int LANE_COUNT = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // id_word0[63:0], id_word1, id_word2, id_word3, out_index[31:0]
  input  wire logic [287:0] in_tdata,
  input  wire logic         in_tlast,   // last_of_tx
  input  wire logic         in_tuser,   // no_inputs
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // lane[3:0], anchor_word0[63:0], anchor_word1, anchor_word2, anchor_word3, 4 zero bits
  output logic [263:0]      out_tdata
);
  import olms_pkg::*;

  item_t        in_item, q_item;
  logic         q_valid, q_pop;
  logic [3:0]   lane;
  logic [255:0] anchor;

  // Unpack the input beat.
  always_comb begin
    for (int i = 0; i < 4; i++) in_item.id[i] = in_tdata[64*i +: 64];
    in_item.idx  = in_tdata[287:256];
    in_item.last = in_tlast;
    in_item.noin = in_tuser;
  end

  // Front end: hold up to two beats while the back end hashes.
  olms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_item  (in_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  // Back end: hash, keep the minimum, reduce the lane, hold the result beat.
  olms_back #(
    .LANE_COUNT (LANE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_lane   (lane),
    .out_anchor (anchor)
  );

  assign out_tdata = {4'd0, anchor, lane};
endmodule
`default_nettype wire

FILE: rtl/olms_queue.sv
// Front end: accepts outpoint beats into a two-entry queue ahead of the hash engine.
`default_nettype none
module olms_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire olms_pkg::item_t wr_item,
  output logic                rd_valid,
  input  wire logic           rd_pop,
  output olms_pkg::item_t     rd_item
);
  import olms_pkg::*;

  item_t       mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/olms_sha.sv
// Double SHA-256 engine over one 36-byte outpoint, one round per cycle.
`default_nettype none
module olms_sha (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [255:0]  id,      // id_word0 in bits 63:0
  input  wire logic [31:0]   idx,
  output logic               done,
  output logic [255:0]       digest   // {word3, word2, word1, word0}
);
  import olms_pkg::*;

  logic [7:0][31:0] st_r;       // st_r[0] = a ... st_r[7] = h
  logic [31:0]      win_r [16];
  logic [5:0]       rnd_r;
  logic             busy_r, fin_r, second_r, done_r;
  logic [255:0]     dig_r;

  logic [31:0] s0, s1, wn, t1, t2, bs0, bs1, ch, mj;
  logic [7:0][31:0] hsum;

  always_comb begin
    s0  = {win_r[1][6:0], win_r[1][31:7]} ^ {win_r[1][17:0], win_r[1][31:18]}
          ^ (win_r[1] >> 3);
    s1  = {win_r[14][16:0], win_r[14][31:17]} ^ {win_r[14][18:0], win_r[14][31:19]}
          ^ (win_r[14] >> 10);
    wn  = win_r[0] + s0 + win_r[9] + s1;
    bs1 = {st_r[4][5:0], st_r[4][31:6]} ^ {st_r[4][10:0], st_r[4][31:11]}
          ^ {st_r[4][24:0], st_r[4][31:25]};
    ch  = (st_r[4] & st_r[5]) ^ (~st_r[4] & st_r[6]);
    t1  = st_r[7] + bs1 + ch + sha_k(rnd_r) + win_r[0];
    bs0 = {st_r[0][1:0], st_r[0][31:2]} ^ {st_r[0][12:0], st_r[0][31:13]}
          ^ {st_r[0][21:0], st_r[0][31:22]};
    mj  = (st_r[0] & st_r[1]) ^ (st_r[0] & st_r[2]) ^ (st_r[1] & st_r[2]);
    t2  = bs0 + mj;
    for (int i = 0; i < 8; i++) hsum[i] = SHA_IV[i] + st_r[i];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r <= SHA_IV;
      for (int i = 0; i < 4; i++) begin
        win_r[2*i]   <= id[64*i+32 +: 32];
        win_r[2*i+1] <= id[64*i +: 32];
      end
      win_r[8]  <= swap32(idx);
      win_r[9]  <= SHA_PAD_ONE;
      for (int i = 10; i < 15; i++) win_r[i] <= '0;
      win_r[15] <= SHA_LEN_BLK1;
    end else if (busy_r) begin
      st_r <= {st_r[6], st_r[5], st_r[4], st_r[3] + t1,
               st_r[2], st_r[1], st_r[0], t1 + t2};
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= wn;
    end else if (fin_r && !second_r) begin
      st_r <= SHA_IV;
      for (int i = 0; i < 8; i++) win_r[i] <= hsum[i];
      win_r[8]  <= SHA_PAD_ONE;
      for (int i = 9; i < 15; i++) win_r[i] <= '0;
      win_r[15] <= SHA_LEN_BLK2;
    end
    if (fin_r && second_r) begin
      for (int i = 0; i < 4; i++) dig_r[64*i +: 64] <= {hsum[2*i], hsum[2*i+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      done_r   <= 1'b0;
      rnd_r    <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        second_r <= 1'b0;
        rnd_r    <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        if (!second_r) begin
          second_r <= 1'b1;
          busy_r   <= 1'b1;
          rnd_r    <= '0;
        end else begin
          second_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign digest = dig_r;
endmodule
`default_nettype wire

FILE: rtl/olms_back.sv
// Back end: runs the hash, keeps the minimum digest, reduces the lane and holds the result.
`default_nettype none
module olms_back #(
  parameter int LANE_COUNT = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire olms_pkg::item_t q_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [3:0]           out_lane,
  output logic [255:0]         out_anchor   // anchor_word0 in bits 63:0
);
  import olms_pkg::*;

  localparam int RW = $clog2(LANE_COUNT + 1) + 1;

  bk_state_t      st_r, st_nxt;
  logic           have_r, last_r;
  logic [255:0]   best_r, anchor_r;
  logic [63:0]    val_r;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [2:0]     cnt_r;
  logic           ovalid_r;
  logic [3:0]     olane_r;
  logic [255:0]   oanchor_r;

  logic           sha_start, sha_done, take;
  logic [255:0]   sha_dig, dig_be, best_be;

  olms_sha u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sha_start),
    .id     (q_item.id),
    .idx    (q_item.idx),
    .done   (sha_done),
    .digest (sha_dig)
  );

  // Order words so word0 is most significant for the lexicographic compare.
  assign dig_be  = {sha_dig[63:0], sha_dig[127:64], sha_dig[191:128], sha_dig[255:192]};
  assign best_be = {best_r[63:0], best_r[127:64], best_r[191:128], best_r[255:192]};
  assign take    = !have_r || (dig_be < best_be);

  // Folds one byte of the value into the remainder per cycle, most significant first.
  always_comb begin
    rem_nxt = rem_r;
    for (int b = 7; b >= 0; b--) begin
      rem_nxt = {rem_nxt[RW-2:0], val_r[56+b]};
      if (rem_nxt >= RW'(LANE_COUNT)) rem_nxt = rem_nxt - RW'(LANE_COUNT);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    sha_start = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.noin) begin
            st_nxt = BK_MOD;
          end else begin
            sha_start = 1'b1;
            st_nxt    = BK_HASH;
          end
        end
      end
      BK_HASH: begin
        if (sha_done) st_nxt = last_r ? BK_MOD : BK_IDLE;
      end
      BK_MOD: begin
        if (cnt_r == 3'd7) st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!ovalid_r || out_ready) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      have_r   <= 1'b0;
      best_r   <= '0;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_IDLE && q_valid && q_item.noin) have_r <= 1'b0;
      if (st_r == BK_HASH && sha_done) begin
        if (take) best_r <= sha_dig;
        have_r <= !last_r;
      end
      cnt_r <= (st_r == BK_MOD) ? cnt_r + 3'd1 : 3'd0;
      if (st_r == BK_OUT && (!ovalid_r || out_ready)) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE && q_valid) begin
      last_r   <= q_item.last;
      anchor_r <= q_item.id;
      val_r    <= swap64(q_item.id[0]);
      rem_r    <= '0;
    end
    if (st_r == BK_HASH && sha_done) begin
      anchor_r <= take ? sha_dig : best_r;
      val_r    <= swap64(take ? sha_dig[63:0] : best_r[63:0]);
      rem_r    <= '0;
    end
    if (st_r == BK_MOD) begin
      rem_r <= rem_nxt;
      val_r <= {val_r[55:0], 8'd0};
    end
    if (st_r == BK_OUT && (!ovalid_r || out_ready)) begin
      olane_r   <= 4'(rem_r);
      oanchor_r <= anchor_r;
    end
  end

  assign out_valid  = ovalid_r;
  assign out_lane   = olane_r;
  assign out_anchor = oanchor_r;
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the outpoint min-hash lane select core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import olms_pkg::*;

  localparam int LANES = 16;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;   // id_word0, id_word1, id_word2, id_word3, out_index (low to high)
  logic         in_tlast;   // last_of_tx
  logic         in_tuser;   // no_inputs
  logic         out_tvalid;
  logic         out_tready;
  logic [263:0] out_tdata;  // lane, anchor_word0..3, zero pad (low to high)

  typedef struct {
    logic [3:0]  lane;
    logic [63:0] anchor [4];
  } lane_pick_t;

  item_t      pending_beats[$];
  lane_pick_t expected_picks[$];
  logic [63:0] held_min [4];
  bit          min_valid;
  int          in_wait;
  int          out_wait;
  bit          stimulus_done;
  bit          failed;

  outpoint_min_hash_lane_select_core #(.LANE_COUNT(LANES)) u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Plain SHA-256 compression of one block from the initial hash.
  function automatic void sha_block(input logic [31:0] blk [16], output logic [31:0] h [8]);
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]} ^ (w[i-15] >> 3);
      s1 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]} ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) r[i] = SHA_IV[i];
    for (int i = 0; i < 64; i++) begin
      s1 = {r[4][5:0], r[4][31:6]} ^ {r[4][10:0], r[4][31:11]} ^ {r[4][24:0], r[4][31:25]};
      t1 = r[7] + s1 + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_k(i[5:0]) + w[i];
      s0 = {r[0][1:0], r[0][31:2]} ^ {r[0][12:0], r[0][31:13]} ^ {r[0][21:0], r[0][31:22]};
      t2 = s0 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] = SHA_IV[i] + r[i];
  endfunction

  function automatic lane_pick_t make_pick(input logic [63:0] a [4]);
    lane_pick_t p;
    logic [63:0] le;
    le = {a[0][7:0], a[0][15:8], a[0][23:16], a[0][31:24],
          a[0][39:32], a[0][47:40], a[0][55:48], a[0][63:56]};
    p.lane = 4'(le % 64'(LANES));
    for (int i = 0; i < 4; i++) p.anchor[i] = a[i];
    return p;
  endfunction

  // Track the running minimum double hash; queue a pick on a closing or no-inputs beat.
  task automatic predict_lane(input item_t it);
    logic [31:0] blk [16];
    logic [31:0] h1 [8];
    logic [31:0] h2 [8];
    logic [63:0] dig [4];
    logic [63:0] own [4];
    bit          less;
    if (it.noin) begin
      for (int i = 0; i < 4; i++) own[i] = it.id[i];
      expected_picks.push_back(make_pick(own));
      min_valid = 0;
      return;
    end
    for (int i = 0; i < 16; i++) blk[i] = '0;
    for (int i = 0; i < 4; i++) begin
      blk[2*i] = it.id[i][63:32];
      blk[2*i+1] = it.id[i][31:0];
    end
    blk[8] = {it.idx[7:0], it.idx[15:8], it.idx[23:16], it.idx[31:24]};
    blk[9] = SHA_PAD_ONE;
    blk[15] = SHA_LEN_BLK1;
    sha_block(blk, h1);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    for (int i = 0; i < 8; i++) blk[i] = h1[i];
    blk[8] = SHA_PAD_ONE;
    blk[15] = SHA_LEN_BLK2;
    sha_block(blk, h2);
    for (int i = 0; i < 4; i++) dig[i] = {h2[2*i], h2[2*i+1]};
    less = 0;
    for (int i = 3; i >= 0; i--) if (dig[i] != held_min[i]) less = dig[i] < held_min[i];
    if (!min_valid || less) begin
      held_min = dig;
      min_valid = 1;
    end
    if (it.last) begin
      expected_picks.push_back(make_pick(held_min));
      min_valid = 0;
    end
  endtask

  function automatic item_t rand_beat(input bit last, input bit noin);
    item_t it;
    for (int i = 0; i < 4; i++) begin
      it.id[i] = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: it.id[i] = '0;
        1: it.id[i] = '1;
        default: ;
      endcase
    end
    it.idx = $urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 3)) : $urandom;
    it.last = last;
    it.noin = noin;
    return it;
  endfunction

  initial begin
    int    n;
    item_t it;
    rst_n = 1'b0;
    failed = 0;
    stimulus_done = 0;
    // Directed: field extremes, single and multi-outpoint transactions, duplicates.
    it = '{id: '{default: '0}, idx: '0, last: 1'b1, noin: 1'b0};
    pending_beats.push_back(it);
    it = '{id: '{default: '1}, idx: '1, last: 1'b1, noin: 1'b0};
    pending_beats.push_back(it);
    it = '{id: '{default: '0}, idx: '0, last: 1'b0, noin: 1'b1};
    pending_beats.push_back(it);
    it = '{id: '{default: '1}, idx: '1, last: 1'b1, noin: 1'b1};
    pending_beats.push_back(it);
    // Equal digests: the same outpoint twice, then a closing one.
    it = rand_beat(0, 0);
    pending_beats.push_back(it);
    pending_beats.push_back(it);
    it.last = 1;
    pending_beats.push_back(it);
    // Partial transaction dropped by a no-inputs beat.
    pending_beats.push_back(rand_beat(0, 0));
    pending_beats.push_back(rand_beat(0, 0));
    pending_beats.push_back(rand_beat(1, 1));
    for (int k = 0; k < 4; k++) pending_beats.push_back(rand_beat(k == 3, 0));
    // Random transactions, mostly well formed, some broken by a stray no-inputs beat.
    n = pending_beats.size();
    while (n < 1100) begin
      int len;
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0) pending_beats.push_back(rand_beat(1'($urandom), 1));
        else pending_beats.push_back(rand_beat(k == len - 1, 0));
        n++;
      end
      if ($urandom_range(0, 7) == 0) begin
        pending_beats.push_back(rand_beat(1'($urandom), 1));
        n++;
      end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Drive input beats with a random hold-off before each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      in_tuser  <= 1'b0;
      in_wait   = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
      min_valid = 0;
      for (int i = 0; i < 4; i++) held_min[i] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_lane(pending_beats.pop_front());
        in_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if ((!in_tvalid || in_tready) && in_wait == 0 && pending_beats.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_beats[0].idx, pending_beats[0].id[3], pending_beats[0].id[2],
                      pending_beats[0].id[1], pending_beats[0].id[0]};
        in_tlast  <= pending_beats[0].last;
        in_tuser  <= pending_beats[0].noin;
      end else begin
        if (in_tready) in_tvalid <= 1'b0;
        if (in_wait > 0 && (!in_tvalid || in_tready)) in_wait = in_wait - 1;
      end
      if (pending_beats.size() == 0) stimulus_done <= 1;
    end
  end

  // Monitor: stall the result side at random, compare each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, out_tdata);
          failed = 1;
        end else begin
          lane_pick_t e;
          e = expected_picks.pop_front();
          if (out_tdata[3:0] !== e.lane) begin
            $display("%0t: lane expected %0d actual %0d", $realtime, e.lane, out_tdata[3:0]);
            failed = 1;
          end
          for (int i = 0; i < 4; i++)
            if (out_tdata[4 + 64*i +: 64] !== e.anchor[i]) begin
              $display("%0t: anchor_word%0d expected %h actual %h", $realtime, i,
                       e.anchor[i], out_tdata[4 + 64*i +: 64]);
              failed = 1;
            end
        end
        out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (out_wait > 0) begin
        out_wait = out_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (expected_picks.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed && expected_picks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/olms_pkg.sv
rtl/olms_queue.sv
rtl/olms_sha.sv
rtl/olms_back.sv
rtl/outpoint_min_hash_lane_select_core.sv
bench/tb.sv
